// ----- hw/rtl/rsbv_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsbv_pkg
// Shared constants, request codes, types and bit-count helpers for the
// rank/select bit vector.
// ----------------------------------------------------------------------------
package rsbv_pkg;

	localparam int WORD_BITS     = 32;
	localparam int WORD_SHIFT    = 5;
	localparam int DEF_NUM_WORDS = 1024;
	localparam int ANS_W         = 16;
	localparam logic [7:0] BYTE_MASK = 8'hFF;

	// Request codes.
	localparam logic [2:0] REQ_APPEND  = 3'd0;
	localparam logic [2:0] REQ_READ    = 3'd1;
	localparam logic [2:0] REQ_RANK1   = 3'd2;
	localparam logic [2:0] REQ_RANK0   = 3'd3;
	localparam logic [2:0] REQ_SELECT1 = 3'd4;
	localparam logic [2:0] REQ_SELECT0 = 3'd5;
	localparam logic [2:0] REQ_CLEAR   = 3'd6;

	// Start of an in-word select and its result.
	typedef struct packed {
		logic        start;
		logic [31:0] word;
		logic [5:0]  k;
	} wsel_cmd_t;

	typedef struct packed {
		logic       done;
		logic [4:0] pos;
	} wsel_res_t;

	// Number of ones in one byte.
	function automatic logic [3:0] ones8(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			n = n + 4'(b[i]);
		end
		return n;
	endfunction

	// Number of ones in one word.
	function automatic logic [5:0] ones32(input logic [31:0] w);
		logic [5:0] n;
		n = 6'd0;
		for (int i = 0; i < 4; i++) begin
			n = n + 6'(ones8(w[8*i +: 8] & BYTE_MASK));
		end
		return n;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/rsbv_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsbv_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module rsbv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic             re,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read share one port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/rsbv_wsel.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsbv_wsel
// In-word select: finds the k-th one of a 32-bit word, one byte per cycle.
// ----------------------------------------------------------------------------
module rsbv_wsel
	import rsbv_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire wsel_cmd_t cmd,
	output wsel_res_t      res
);

	logic        busy_q;
	logic [1:0]  idx_q;
	logic [31:0] word_q;
	logic [5:0]  k_q;
	logic [7:0]  cur_byte;
	logic [3:0]  cur_cnt;
	logic        hit;
	logic [2:0]  hit_pos;
	logic [3:0]  run;
	logic        found;

	assign cur_byte = word_q[8*idx_q +: 8];
	assign cur_cnt  = ones8(cur_byte);
	assign hit      = busy_q && (k_q <= 6'(cur_cnt));

	// Position of the k-th one inside the current byte.
	always_comb begin
		run     = 4'd0;
		found   = 1'b0;
		hit_pos = 3'd0;
		for (int i = 0; i < 8; i++) begin
			run = run + 4'(cur_byte[i]);
			if (!found && cur_byte[i] && 6'(run) == k_q) begin
				found   = 1'b1;
				hit_pos = 3'(i);
			end
		end
	end

	// Step through the bytes until the count falls in one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (hit) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			word_q <= cmd.word;
			k_q    <= cmd.k;
		end else if (busy_q && !hit) begin
			k_q <= k_q - 6'(cur_cnt);
		end
	end

	assign res.done = hit;
	assign res.pos  = {idx_q, hit_pos};

endmodule
`default_nettype wire

// ----- hw/rtl/rank_select_bit_vector.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rank_select_bit_vector
// Bit store with a per-word prefix count directory; serves append, read,
// rank, select and clear requests.
// ----------------------------------------------------------------------------
//  channel | signals                                   | role
//  in      | in_valid, in_ready, req_type, bit_value,  | one request word
//          | operand                                   |
//  out     | out_valid, out_ready, answer, error       | one result word
//
// One request at a time. Append, read and rank make one RAM read, with a
// write-back for append; an append that opens a new word writes it without
// a read. Requests answered from the counts alone go straight to the
// response. Select runs a binary search over the prefix counts, reads the
// chosen word and then scans it byte by byte for the wanted bit.
// The RAM holds word bits and prefix count side by side in one entry.
// Reset clears length and ones count but not the RAM, which needs no clearing.
// A new request is taken while a result waits on the output; a finished
// request then holds in its last cycle until the output register is free.
// ----------------------------------------------------------------------------
module rank_select_bit_vector
	import rsbv_pkg::*;
#(
	parameter int NUM_WORDS = DEF_NUM_WORDS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  req_type,
	input  wire logic        bit_value,
	input  wire logic [15:0] operand,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      answer,
	output logic             error
);

	localparam int CAP   = NUM_WORDS * WORD_BITS;
	localparam int LEN_W = $clog2(CAP + 1);
	localparam int AW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int CW    = (LEN_W > 16) ? LEN_W : 16;
	localparam int EW    = LEN_W + WORD_BITS;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_APP   = 9'b000000010,
		ST_RD    = 9'b000000100,
		ST_RANK  = 9'b000001000,
		ST_SRCH  = 9'b000010000,
		ST_SWAIT = 9'b000100000,
		ST_SCRD  = 9'b001000000,
		ST_SCAN  = 9'b010000000,
		ST_RESP  = 9'b100000000
	} state_t;

	state_t             state_q;
	logic [LEN_W-1:0]   len_q, ones_q;
	logic               want_one_q, bit_q, rank1_q;
	logic [CW-1:0]      cnt_q;
	logic [AW-1:0]      lo_q, hi_q, mid_q;
	logic [4:0]         r_q;
	logic [15:0]        res_ans_q;
	logic               res_err_q;
	logic               out_valid_q;
	logic [15:0]        answer_q;
	logic               error_q;

	logic               accept;
	logic [CW-1:0]      opd_x, len_x, ones_x, zeros_x, total_x;
	logic [AW-1:0]      pos_w, app_w, last_w, mid_c;
	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_addr;
	logic [EW-1:0]      ram_wdata, ram_rdata;
	logic [LEN_W-1:0]   rd_prefix, bw_cur, lo_base, mid_base;
	logic [31:0]        rd_word;
	logic [LEN_W-1:0]   rank_ones;
	wsel_cmd_t          wcmd;
	wsel_res_t          wres;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	assign opd_x   = CW'(operand);
	assign len_x   = CW'(len_q);
	assign ones_x  = CW'(ones_q);
	assign zeros_x = CW'(len_q - ones_q);
	assign total_x = (req_type == REQ_SELECT1) ? ones_x : zeros_x;
	assign pos_w   = AW'(opd_x >> WORD_SHIFT);
	assign app_w   = AW'(len_q >> WORD_SHIFT);
	assign last_w  = AW'((len_q - LEN_W'(1)) >> WORD_SHIFT);
	assign mid_c   = AW'(((AW+1)'(lo_q) + (AW+1)'(hi_q) + (AW+1)'(1)) >> 1);

	assign rd_prefix = ram_rdata[EW-1:WORD_BITS];
	assign rd_word   = ram_rdata[WORD_BITS-1:0];
	assign lo_base   = LEN_W'(lo_q) << WORD_SHIFT;
	assign mid_base  = LEN_W'(mid_q) << WORD_SHIFT;
	assign bw_cur    = want_one_q ? rd_prefix
	                              : (((state_q == ST_SWAIT) ? mid_base : lo_base) - rd_prefix);
	assign rank_ones = rd_prefix + LEN_W'(ones32(rd_word & ~(32'hFFFF_FFFF << r_q)));

	// RAM port control.
	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = lo_q;
		ram_wdata = {rd_prefix, rd_word | (32'(bit_q) << r_q)};
		unique case (state_q)
			ST_IDLE: begin
				ram_addr = (req_type == REQ_APPEND) ? app_w : pos_w;
				if (accept && req_type == REQ_APPEND && len_q < LEN_W'(CAP)) begin
					if (len_q[4:0] == 5'd0) begin
						ram_we    = 1'b1;
						ram_wdata = {ones_q, 32'(bit_value)};
					end else begin
						ram_re = 1'b1;
					end
				end else if (accept) begin
					ram_re = 1'b1;
				end
			end
			ST_APP: begin
				ram_we = 1'b1;
			end
			ST_SRCH: begin
				ram_re   = 1'b1;
				ram_addr = (lo_q == hi_q) ? lo_q : mid_c;
			end
			default: begin
			end
		endcase
	end

	rsbv_ram #(
		.WIDTH(EW),
		.DEPTH(NUM_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Start the in-word scan once the chosen word is read.
	assign wcmd.start = (state_q == ST_SCRD);
	assign wcmd.word  = want_one_q ? rd_word : ~rd_word;
	assign wcmd.k     = 6'(cnt_q - CW'(bw_cur));

	rsbv_wsel u_wsel (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (wcmd),
		.res    (wres)
	);

	// Request sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= '0;
			ones_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RESP;
						unique case (req_type)
							REQ_APPEND: begin
								if (len_q < LEN_W'(CAP)) begin
									if (len_q[4:0] == 5'd0) begin
										len_q  <= len_q + LEN_W'(1);
										ones_q <= ones_q + LEN_W'(bit_value);
									end else begin
										state_q <= ST_APP;
									end
								end
							end
							REQ_READ: begin
								if (opd_x < len_x) state_q <= ST_RD;
							end
							REQ_RANK1, REQ_RANK0: begin
								if (opd_x < len_x) state_q <= ST_RANK;
							end
							REQ_SELECT1, REQ_SELECT0: begin
								if (operand != 16'd0 && opd_x <= total_x) state_q <= ST_SRCH;
							end
							REQ_CLEAR: begin
								len_q  <= '0;
								ones_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_APP: begin
					len_q   <= len_q + LEN_W'(1);
					ones_q  <= ones_q + LEN_W'(bit_q);
					state_q <= ST_RESP;
				end
				ST_RD, ST_RANK: state_q <= ST_RESP;
				ST_SRCH: state_q <= (lo_q == hi_q) ? ST_SCRD : ST_SWAIT;
				ST_SWAIT: state_q <= ST_SRCH;
				ST_SCRD: state_q <= ST_SCAN;
				ST_SCAN: begin
					if (wres.done) state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (!out_valid_q || out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the request in flight.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				want_one_q <= (req_type == REQ_SELECT1);
				rank1_q    <= (req_type == REQ_RANK1);
				bit_q      <= bit_value;
				cnt_q      <= opd_x;
				r_q        <= (req_type == REQ_APPEND) ? len_q[4:0] : operand[4:0];
				lo_q       <= (req_type == REQ_APPEND) ? app_w : AW'(0);
				hi_q       <= last_w;
				// A rank at the very end is answered from the totals.
				res_ans_q  <= ((req_type == REQ_RANK1 || req_type == REQ_RANK0)
				               && opd_x == len_x)
				              ? ((req_type == REQ_RANK1) ? 16'(ones_q) : 16'(opd_x - ones_x))
				              : 16'd0;
				priority if (req_type == REQ_APPEND) begin
					res_err_q <= (len_q >= LEN_W'(CAP));
				end else if (req_type == REQ_READ) begin
					res_err_q <= (opd_x >= len_x);
				end else if (req_type == REQ_RANK1 || req_type == REQ_RANK0) begin
					res_err_q <= (opd_x > len_x);
				end else if (req_type == REQ_SELECT1 || req_type == REQ_SELECT0) begin
					res_err_q <= (operand != 16'd0) && (opd_x > total_x);
				end else if (req_type == REQ_CLEAR) begin
					res_err_q <= 1'b0;
				end else begin
					res_err_q <= 1'b1;
				end
			end
			ST_RD: res_ans_q <= 16'(rd_word[r_q]);
			ST_RANK: begin
				res_ans_q <= rank1_q ? 16'(rank_ones) : 16'(cnt_q - CW'(rank_ones));
			end
			ST_SRCH: mid_q <= mid_c;
			ST_SWAIT: begin
				if (CW'(bw_cur) < cnt_q) lo_q <= mid_q;
				else                     hi_q <= mid_q - AW'(1);
			end
			ST_SCAN: begin
				if (wres.done) begin
					res_ans_q <= 16'({1'b0, lo_q, wres.pos} + (AW+6)'(1));
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESP && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && (!out_valid_q || out_ready)) begin
			answer_q <= res_ans_q;
			error_q  <= res_err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign answer    = answer_q;
	assign error     = error_q;

`ifndef SYNTH
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(CAP)) else $error("length above capacity");
	a_ones_len: assert property (@(posedge clk) disable iff (!arst_n)
		ones_q <= len_q) else $error("ones count above length");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_type == REQ_CLEAR |=> len_q == '0 && ones_q == '0)
		else $error("clear did not empty the store");
	a_scan_state: assert property (@(posedge clk) disable iff (!arst_n)
		wres.done |-> state_q == ST_SCAN) else $error("scan result outside select");
	a_ram_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re)) else $error("RAM read and write together");
`endif

endmodule
`default_nettype wire
